// ----- hw/rtl/tps_pkg.sv -----
// Shared constants, types and helper functions for the text pattern scrubber.
package tps_pkg;

   localparam int WinDepth  = 8;
   localparam int CharSlots = 8;
   localparam int FillW     = $clog2(WinDepth + 1);
   localparam int DiscW     = $clog2(WinDepth);
   localparam int LenW      = 4;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 64;

   typedef enum logic [CsrIdxW-1:0] {
      REG_UNWANTED_CHARS  = 3'd0,
      REG_CHAR_COUNT      = 3'd1,
      REG_STRING_ZERO     = 3'd2,
      REG_STRING_ONE      = 3'd3,
      REG_CONTAINER_HEAD  = 3'd4,
      REG_CONTAINER_TAIL  = 3'd5,
      REG_PATTERN_LENGTHS = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic write_en;
      logic shift_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic [7:0] str0;
      logic [7:0] str1;
      logic [7:0] head;
      logic [7:0] tail;
   } pat_bytes_type;

   typedef struct packed {
      logic str0;
      logic str1;
      logic head;
      logic tail;
   } cell_eq_type;

   typedef struct packed {
      logic             kept;
      logic             in_cont;
      logic [DiscW-1:0] discard;
   } decide_type;

   // Lengths beyond the window depth compare only the bytes the window holds.
   function automatic logic [FillW-1:0] clamp_len(input logic [LenW-1:0] raw);
      if (raw > LenW'(WinDepth)) begin
         return FillW'(WinDepth);
      end else begin
         return FillW'(raw);
      end
   endfunction

endpackage

// ----- hw/rtl/tps_cell.sv -----
// One window cell: holds a byte, compares it against its pattern bytes, shifts left.
module tps_cell import tps_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    new_byte,
   input  logic [7:0]    neighbor_byte,
   input  pat_bytes_type pat,
   output logic [7:0]    eff_byte,
   output cell_eq_type   eq
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // A byte written into this slot is visible to the compares in the same cycle.
   assign eff_byte = ctrl.write_en ? new_byte : data_ff;

   always_comb begin
      data_in = ctrl.shift_en ? neighbor_byte : eff_byte;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign eq.str0 = (eff_byte == pat.str0);
   assign eq.str1 = (eff_byte == pat.str1);
   assign eq.head = (eff_byte == pat.head);
   assign eq.tail = (eff_byte == pat.tail);

endmodule

// ----- hw/rtl/tps_decide.sv -----
// Priority decision on the front byte of the window and the next drop state.
module tps_decide import tps_pkg::*; (
   input  cell_eq_type          eq [WinDepth],
   input  logic [7:0]           front_byte,
   input  logic [FillW-1:0]     count,
   input  logic                 in_cont,
   input  logic [DiscW-1:0]     discard,
   input  logic [LenW*4-1:0]    lengths,
   input  logic [CharSlots*8-1:0] chars,
   input  logic [LenW-1:0]      char_count,
   output decide_type           result
);

   logic [FillW-1:0]    l0, l1, lh, lt;
   logic [WinDepth-1:0] eq0, eq1, eqh, eqt;
   logic                m0, m1, mh, mt;
   logic                cont_on;
   logic                listed;
   logic [LenW-1:0]     n_chars;

   function automatic logic pat_match(input logic [WinDepth-1:0] eqv,
                                      input logic [FillW-1:0] len,
                                      input logic [FillW-1:0] cnt);
      logic ok;
      ok = (len != '0) && (len <= cnt);
      for (int k = 0; k < WinDepth; k++) begin
         if ((FillW'(k) < len) && !eqv[k]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   always_comb begin
      for (int k = 0; k < WinDepth; k++) begin
         eq0[k] = eq[k].str0;
         eq1[k] = eq[k].str1;
         eqh[k] = eq[k].head;
         eqt[k] = eq[k].tail;
      end
   end

   assign l0 = clamp_len(lengths[LenW-1:0]);
   assign l1 = clamp_len(lengths[2*LenW-1:LenW]);
   assign lh = clamp_len(lengths[3*LenW-1:2*LenW]);
   assign lt = clamp_len(lengths[4*LenW-1:3*LenW]);

   assign m0 = pat_match(eq0, l0, count);
   assign m1 = pat_match(eq1, l1, count);
   assign mh = pat_match(eqh, lh, count);
   assign mt = pat_match(eqt, lt, count);

   // A container needs both its head and its tail enabled.
   assign cont_on = (lh != '0) && (lt != '0);

   assign n_chars = (char_count > LenW'(CharSlots)) ? LenW'(CharSlots) : char_count;

   always_comb begin
      listed = 1'b0;
      for (int c = 0; c < CharSlots; c++) begin
         if ((LenW'(c) < n_chars) && (chars[8*c +: 8] == front_byte)) begin
            listed = 1'b1;
         end
      end
   end

   always_comb begin
      result.kept    = 1'b0;
      result.in_cont = in_cont;
      result.discard = discard;
      if (discard != '0) begin
         result.discard = discard - DiscW'(1);
      end else if (in_cont) begin
         if (cont_on && mt) begin
            result.in_cont = 1'b0;
            result.discard = DiscW'(lt - FillW'(1));
         end
      end else if (cont_on && mh) begin
         result.in_cont = 1'b1;
         result.discard = DiscW'(lh - FillW'(1));
      end else if (m0) begin
         result.discard = DiscW'(l0 - FillW'(1));
      end else if (m1) begin
         result.discard = DiscW'(l1 - FillW'(1));
      end else if (!listed) begin
         result.kept = 1'b1;
      end
   end

endmodule

// ----- hw/rtl/text_pattern_scrubber.sv -----
// Top level of the text pattern scrubber: configuration, window cell chain and result register.
//
// The scrubber removes unwanted material from a byte stream. Each request on the req_
// channel carries one byte and a flag that marks the final byte of the stream. Surviving
// bytes leave on the rsp_ channel in order; each response carries a byte, a flag that says
// whether the byte is real, and an end flag on the last response of a stream.
// Bytes pass through an eight-byte lookahead window built as a chain of cells. Once the
// window is full, each further request but the final one decides the oldest byte in the
// cycle it is accepted, so a kept byte it pushes out appears on rsp_ in the next cycle.
// While the receiver keeps up, one request is accepted every cycle.
// The request that carries the final byte starts a flush: the window drains one byte per
// cycle while the receiver keeps up, then the end response follows, and no request is
// accepted during the flush. A stream that keeps nothing still gets one end response
// with no byte. The flush clears the window and the drop state as a reset does, but
// keeps configuration.
// When the receiver stalls, the result register holds its response and the window stops
// with it; req_ready falls in the same cycle. The synchronous reset clears the window, the
// drop state, all configuration registers and the response valid. The user must write
// configuration through csr_ only while idle; the block itself does not enforce this.
module text_pattern_scrubber import tps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_has_byte,
   output logic                rsp_is_end,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   // Configuration registers.
   logic [CharSlots*8-1:0] chars_ff;
   logic [LenW-1:0]        char_count_ff;
   logic [WinDepth*8-1:0]  str0_ff, str1_ff, head_ff, tail_ff;
   logic [LenW*4-1:0]      lengths_ff;

   // Stream control state.
   logic [FillW-1:0] fill_ff, fill_in;
   logic             flush_ff, flush_in;
   logic             inside_ff, inside_in;
   logic [DiscW-1:0] disc_ff, disc_in;

   // Flush results are held back by one so the end flag lands on the last kept byte.
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff, pend_byte_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_has_ff, rsp_has_in;
   logic       rsp_end_ff, rsp_end_in;

   logic             advance;
   logic             accept;
   logic             full_step;
   logic             flush_step;
   logic             flush_end;
   logic             decide_fire;
   logic [FillW-1:0] count;

   cell_ctrl_type ctrl [WinDepth];
   logic [7:0]    eff_bytes [WinDepth];
   cell_eq_type   eqs [WinDepth];
   decide_type    dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff      <= '0;
         char_count_ff <= '0;
         str0_ff       <= '0;
         str1_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         lengths_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            REG_UNWANTED_CHARS:  chars_ff      <= csr_data[CharSlots*8-1:0];
            REG_CHAR_COUNT:      char_count_ff <= csr_data[LenW-1:0];
            REG_STRING_ZERO:     str0_ff       <= csr_data[WinDepth*8-1:0];
            REG_STRING_ONE:      str1_ff       <= csr_data[WinDepth*8-1:0];
            REG_CONTAINER_HEAD:  head_ff       <= csr_data[WinDepth*8-1:0];
            REG_CONTAINER_TAIL:  tail_ff       <= csr_data[WinDepth*8-1:0];
            REG_PATTERN_LENGTHS: lengths_ff    <= csr_data[LenW*4-1:0];
            default: begin
            end
         endcase
      end
   end

   // The window and the stream state move only when the result register is free or being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !flush_ff;
   assign accept    = req_valid && req_ready;

   // A request that fills the window, unless it carries the final byte, decides the oldest byte in the same cycle.
   assign full_step   = accept && !req_last_byte && (fill_ff == FillW'(WinDepth - 1));
   assign flush_step  = flush_ff && advance && (fill_ff != '0);
   assign flush_end   = flush_ff && advance && (fill_ff == '0);
   assign decide_fire = full_step || flush_step;
   assign count       = full_step ? FillW'(WinDepth) : fill_ff;

   for (genvar i = 0; i < WinDepth; i++) begin : g_cell
      logic [7:0]    neighbor;
      pat_bytes_type pat;

      if (i == WinDepth - 1) begin : g_end
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = eff_bytes[i+1];
      end

      assign ctrl[i].write_en = accept && (fill_ff == FillW'(i));
      assign ctrl[i].shift_en = decide_fire;
      assign pat.str0 = str0_ff[8*i +: 8];
      assign pat.str1 = str1_ff[8*i +: 8];
      assign pat.head = head_ff[8*i +: 8];
      assign pat.tail = tail_ff[8*i +: 8];

      tps_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl[i]),
         .new_byte      (req_in_byte),
         .neighbor_byte (neighbor),
         .pat           (pat),
         .eff_byte      (eff_bytes[i]),
         .eq            (eqs[i])
      );
   end

   tps_decide u_decide (
      .eq         (eqs),
      .front_byte (eff_bytes[0]),
      .count      (count),
      .in_cont    (inside_ff),
      .discard    (disc_ff),
      .lengths    (lengths_ff),
      .chars      (chars_ff),
      .char_count (char_count_ff),
      .result     (dec)
   );

   always_comb begin
      fill_in       = fill_ff;
      flush_in      = flush_ff;
      inside_in     = inside_ff;
      disc_in       = disc_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      rsp_valid_in  = advance ? 1'b0 : rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_end_in    = rsp_end_ff;

      if (accept && !full_step) begin
         fill_in = fill_ff + FillW'(1);
      end
      if (accept && req_last_byte) begin
         flush_in = 1'b1;
      end

      if (decide_fire) begin
         inside_in = dec.in_cont;
         disc_in   = dec.discard;
      end

      if (full_step && dec.kept) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = eff_bytes[0];
         rsp_has_in   = 1'b1;
         rsp_end_in   = 1'b0;
      end

      if (flush_step) begin
         fill_in = fill_ff - FillW'(1);
         if (dec.kept) begin
            // The previously kept byte is now known not to be the last one.
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_byte_ff;
               rsp_has_in   = 1'b1;
               rsp_end_in   = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_byte_in  = eff_bytes[0];
         end
      end

      if (flush_end) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = pend_valid_ff ? pend_byte_ff : 8'h00;
         rsp_has_in    = pend_valid_ff;
         rsp_end_in    = 1'b1;
         pend_valid_in = 1'b0;
         flush_in      = 1'b0;
         fill_in       = '0;
         inside_in     = 1'b0;
         disc_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         flush_ff      <= 1'b0;
         inside_ff     <= 1'b0;
         disc_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         flush_ff      <= flush_in;
         inside_ff     <= inside_in;
         disc_ff       <= disc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_has_byte = rsp_has_ff;
   assign rsp_is_end   = rsp_end_ff;

`ifndef NO_ASSERTIONS
   // Outside a flush the window never holds a full set of undecided bytes.
   assert property (@(posedge clock) disable iff (reset)
      !flush_ff |-> (fill_ff < FillW'(WinDepth)))
      else $error("window overfilled outside a flush");

   // A held-back flush byte exists only while a flush is running.
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> flush_ff)
      else $error("pending byte outside a flush");

   // The end of a flush leaves the stream state cleared.
   assert property (@(posedge clock) disable iff (reset)
      flush_end |=> (!inside_ff && (disc_ff == '0) && (fill_ff == '0) && !flush_ff))
      else $error("stream state not cleared after flush");

   // Only the end response may come without a byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_end_ff) |-> rsp_has_ff)
      else $error("empty response that is not the end of a stream");
`endif

endmodule
